>>> design/sclt_pkg.sv
// Shared types and character constants of the command-line tokenizer.
package sclt_pkg;

  typedef enum logic [1:0] {
    EV_BYTE      = 2'd0,
    EV_TOKEN_END = 2'd1,
    EV_LINE_END  = 2'd2,
    EV_ERROR     = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WORD  = 2'd1,
    MODE_QUOTE = 2'd2,
    MODE_OPER  = 2'd3
  } lex_mode_t;

  // One classified input byte: up to three events, all sharing one character.
  typedef struct packed {
    logic [1:0]         cnt;
    ev_kind_t [2:0]     kind;
    logic [7:0]         tok;
  } cmd_t;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

endpackage

>>> design/sclt_front.sv
// Front end: accepts bytes, runs the lexer state machine and emits requests.
module sclt_front import sclt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  lex_mode_t  mode_r, mode_nxt;
  logic [7:0] op_char_r, op_char_nxt;
  logic [1:0] op_len_r, op_len_nxt;

  logic       acc, eol, blank, quote, cls1, cls2, extend;
  lex_mode_t  bt_mode;
  logic [7:0] bt_char;
  logic [1:0] bt_len;
  cmd_t       cmd;

  function automatic cmd_t add_ev(cmd_t c, ev_kind_t k);
    cmd_t r;
    r = c;
    r.kind[c.cnt] = k;
    r.cnt = c.cnt + 2'd1;
    return r;
  endfunction

  // Events of a character that starts a token from between tokens.
  function automatic cmd_t add_begin(cmd_t c, logic is_blank, logic is_quote, logic is_one);
    cmd_t r;
    r = c;
    if (!is_blank && !is_quote) begin
      r = add_ev(r, EV_BYTE);
      if (is_one) begin
        r = add_ev(r, EV_TOKEN_END);
      end
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign eol      = in_end_of_input || (in_byte == CH_NL);
  assign blank    = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
  assign quote    = (in_byte == CH_QUOTE);
  assign cls1     = in_byte inside {CH_SEMI, CH_LT, CH_LPAR, CH_RPAR};
  assign cls2     = in_byte inside {CH_GT, CH_AMP, CH_PIPE};
  assign extend   = (op_len_r == 2'd1) && (in_byte == op_char_r) && cls2;

  // State reached when the byte opens a token from between tokens.
  always_comb begin
    bt_char = 8'h00;
    bt_len  = 2'd0;
    if (blank || cls1) begin
      bt_mode = MODE_IDLE;
    end else if (quote) begin
      bt_mode = MODE_QUOTE;
    end else if (cls2) begin
      bt_mode = MODE_OPER;
      bt_char = in_byte;
      bt_len  = 2'd1;
    end else begin
      bt_mode = MODE_WORD;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    op_char_nxt = op_char_r;
    op_len_nxt  = op_len_r;
    case (mode_r)
      MODE_IDLE: begin
        if (!eol) begin
          mode_nxt    = bt_mode;
          op_char_nxt = bt_char;
          op_len_nxt  = bt_len;
        end
      end
      MODE_WORD: begin
        if (eol || blank) begin
          mode_nxt = MODE_IDLE;
        end else if (cls1 || cls2) begin
          mode_nxt    = bt_mode;
          op_char_nxt = bt_char;
          op_len_nxt  = bt_len;
        end
      end
      MODE_QUOTE: begin
        if (eol || quote) begin
          mode_nxt    = MODE_IDLE;
          op_char_nxt = 8'h00;
          op_len_nxt  = 2'd0;
        end
      end
      MODE_OPER: begin
        if (eol || blank) begin
          mode_nxt    = MODE_IDLE;
          op_char_nxt = 8'h00;
          op_len_nxt  = 2'd0;
        end else if (extend) begin
          op_len_nxt = 2'd2;
        end else begin
          mode_nxt    = bt_mode;
          op_char_nxt = bt_char;
          op_len_nxt  = bt_len;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd     = '0;
    cmd.tok = in_byte;
    case (mode_r)
      MODE_IDLE: begin
        if (eol) begin
          cmd = add_ev(cmd, EV_LINE_END);
        end else begin
          cmd = add_begin(cmd, blank, quote, cls1);
        end
      end
      MODE_WORD: begin
        if (eol) begin
          cmd = add_ev(cmd, EV_TOKEN_END);
          cmd = add_ev(cmd, EV_LINE_END);
        end else if (blank) begin
          cmd = add_ev(cmd, EV_TOKEN_END);
        end else if (cls1 || cls2) begin
          cmd = add_ev(cmd, EV_TOKEN_END);
          cmd = add_begin(cmd, blank, quote, cls1);
        end else begin
          cmd = add_ev(cmd, EV_BYTE);
        end
      end
      MODE_QUOTE: begin
        if (eol) begin
          cmd = add_ev(cmd, EV_ERROR);
        end else if (quote) begin
          cmd = add_ev(cmd, EV_TOKEN_END);
        end else begin
          cmd = add_ev(cmd, EV_BYTE);
        end
      end
      MODE_OPER: begin
        if (eol) begin
          cmd = add_ev(cmd, EV_TOKEN_END);
          cmd = add_ev(cmd, EV_LINE_END);
        end else if (blank) begin
          cmd = add_ev(cmd, EV_TOKEN_END);
        end else if (extend) begin
          cmd = add_ev(cmd, EV_BYTE);
        end else begin
          cmd = add_ev(cmd, EV_TOKEN_END);
          cmd = add_begin(cmd, blank, quote, cls1);
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign push     = acc && (cmd.cnt != 2'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      op_char_r <= 8'h00;
      op_len_r  <= 2'd0;
    end else if (acc) begin
      mode_r    <= mode_nxt;
      op_char_r <= op_char_nxt;
      op_len_r  <= op_len_nxt;
    end
  end

endmodule

>>> design/sclt_queue.sv
// Small request queue between the lexer front end and the event back end.
module sclt_queue import sclt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/sclt_back.sv
// Back end: walks the events of the head request into the output register.
module sclt_back import sclt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_token_byte,
  output logic       out_last_of_run
);

  logic       out_valid_r, out_valid_nxt;
  ev_kind_t   kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load, last;
  ev_kind_t   cur_kind;

  // The output register may take a new event when empty or being drained.
  assign load     = !out_valid_r || !out_stall;
  assign cur_kind = head_cmd.kind[idx_r];
  assign last     = (idx_r == head_cmd.cnt - 2'd1);
  assign pop      = load && head_valid && last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        kind_nxt = cur_kind;
        byte_nxt = (cur_kind == EV_BYTE) ? head_cmd.tok : 8'h00;
        last_nxt = last;
        idx_nxt  = last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_token_byte  = byte_r;
  assign out_last_of_run = last_r;

endmodule

>>> design/shell_command_line_tokenizer.sv
// Events of a byte pass through the request queue and then the output register.
// Throughput: one byte per cycle unless the queue is full; a byte with several events
// holds the single event output for each in turn; the queue of QUEUE_DEPTH requests absorbs bursts.
// Bytes that give no event (blanks, opening quotes) pass through the front end alone.
// Reset is synchronous, active low: lexer back between tokens, queue and output emptied.
module shell_command_line_tokenizer import sclt_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_token_byte,
  output logic       out_last_of_run
);

  logic push, pop, head_valid, q_full;
  cmd_t push_cmd, head_cmd;

  sclt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  sclt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (q_full)
  );

  sclt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_token_byte  (out_token_byte),
    .out_last_of_run (out_last_of_run)
  );

  // A line end or an error always closes the run of events of its byte.
  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_LINE_END) |-> out_last_of_run)
    else $error("line end not last of its run");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_ERROR) |-> out_last_of_run)
    else $error("quote error not last of its run");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind != EV_BYTE) |-> (out_token_byte == 8'h00))
    else $error("token byte set on a non-byte event");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !pop |=> q_full || !push)
    else $error("queue pushed while full");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the shell command-line tokenizer.
`timescale 1ns / 100ps

module tb;
  import sclt_pkg::*;

  localparam int CLK_HALF_NS      = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int RANDOM_ITEMS     = 280;
  localparam int LONG_HOLD_CYCLES = 100;
  localparam int WATCHDOG_LIMIT   = 1500;
  localparam int DRAIN_CYCLES     = 8;
  localparam int MAX_PRINTED      = 100;

  localparam logic [7:0] OP_CHARS [7] = '{CH_SEMI, CH_LT, CH_LPAR, CH_RPAR,
                                          CH_GT, CH_AMP, CH_PIPE};

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] tok;
    logic       last;
  } lex_event_t;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic [7:0] in_byte         = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_stall       = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_event_kind;
  logic [7:0] out_token_byte;
  logic       out_last_of_run;

  // Tokenizer state as the testbench sees it, and the events still owed by the block.
  lex_mode_t  lx_mode;
  logic [7:0] lx_op_char;
  logic [1:0] lx_op_len;
  lex_event_t byte_events[$];
  lex_event_t pending_events[$];

  int  mismatches     = 0;
  int  accepted_items = 0;
  int  idle_cycles    = 0;
  bit  quiet          = 1'b0;
  bit  long_hold_req  = 1'b0;

  shell_command_line_tokenizer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_token_byte  (out_token_byte),
    .out_last_of_run (out_last_of_run)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic int op_class(logic [7:0] c);
    if (c == CH_SEMI || c == CH_LT || c == CH_LPAR || c == CH_RPAR) return 1;
    if (c == CH_GT || c == CH_AMP || c == CH_PIPE) return 2;
    return 0;
  endfunction

  function automatic void note_event(ev_kind_t k, logic [7:0] c);
    lex_event_t e;
    e.kind = k;
    e.tok  = (k == EV_BYTE) ? c : 8'h00;
    e.last = 1'b0;
    byte_events.push_back(e);
  endfunction

  function automatic void clear_operator();
    lx_op_char = 8'h00;
    lx_op_len  = 2'd0;
  endfunction

  // A character seen between tokens that is not a line end.
  function automatic void open_token(logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB) return;
    if (c == CH_QUOTE) begin
      lx_mode = MODE_QUOTE;
      return;
    end
    note_event(EV_BYTE, c);
    case (op_class(c))
      1: begin
        note_event(EV_TOKEN_END, c);
        lx_mode = MODE_IDLE;
      end
      2: begin
        lx_mode    = MODE_OPER;
        lx_op_char = c;
        lx_op_len  = 2'd1;
      end
      default: lx_mode = MODE_WORD;
    endcase
  endfunction

  function automatic void lex_predict(logic [7:0] c, logic eoi);
    logic eol;
    logic blank;
    lex_event_t e;
    eol   = eoi || (c == CH_NL);
    blank = (c == CH_SPACE) || (c == CH_TAB);
    byte_events.delete();
    case (lx_mode)
      MODE_IDLE: begin
        if (eol) note_event(EV_LINE_END, c);
        else open_token(c);
      end
      MODE_WORD: begin
        if (eol) begin
          note_event(EV_TOKEN_END, c);
          note_event(EV_LINE_END, c);
          lx_mode = MODE_IDLE;
        end else if (blank) begin
          note_event(EV_TOKEN_END, c);
          lx_mode = MODE_IDLE;
        end else if (op_class(c) != 0) begin
          note_event(EV_TOKEN_END, c);
          lx_mode = MODE_IDLE;
          open_token(c);
        end else begin
          note_event(EV_BYTE, c);
        end
      end
      MODE_QUOTE: begin
        if (c == CH_QUOTE && !eol) begin
          note_event(EV_TOKEN_END, c);
          lx_mode = MODE_IDLE;
        end else if (eol) begin
          // An unclosed quote reports the error alone and drops all state.
          note_event(EV_ERROR, c);
          lx_mode = MODE_IDLE;
          clear_operator();
        end else begin
          note_event(EV_BYTE, c);
        end
      end
      default: begin
        if (eol) begin
          note_event(EV_TOKEN_END, c);
          note_event(EV_LINE_END, c);
          lx_mode = MODE_IDLE;
          clear_operator();
        end else if (blank) begin
          note_event(EV_TOKEN_END, c);
          lx_mode = MODE_IDLE;
          clear_operator();
        end else if (lx_op_len == 2'd1 && c == lx_op_char && op_class(c) == 2) begin
          note_event(EV_BYTE, c);
          lx_op_len = 2'd2;
        end else begin
          note_event(EV_TOKEN_END, c);
          lx_mode = MODE_IDLE;
          clear_operator();
          open_token(c);
        end
      end
    endcase
    foreach (byte_events[i]) begin
      e      = byte_events[i];
      e.last = (i == byte_events.size() - 1);
      pending_events.push_back(e);
    end
  endfunction

  // ------------------------------------------------------------ sender side

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    lex_predict(c, eoi);
    accepted_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // ----------------------------------------------------------- receiver side

  initial begin : rx_stall
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : event_check
    lex_event_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d byte %02h",
                                  out_event_kind, out_token_byte));
      end else begin
        e = pending_events.pop_front();
        if (out_event_kind !== e.kind)
          report_mismatch($sformatf("event kind %0d, want %s", out_event_kind,
                                    e.kind.name()));
        if (out_token_byte !== e.tok)
          report_mismatch($sformatf("token byte %02h, want %02h", out_token_byte, e.tok));
        if (out_last_of_run !== e.last)
          report_mismatch($sformatf("last_of_run %b, want %b", out_last_of_run, e.last));
      end
    end
  end

  // A run that stops moving in both directions is hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("shell_command_line_tokenizer regression: fail");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------ tests

  // A blank, the zero and all-ones bytes, a quote inside a word, newline.
  task automatic test_word_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_text("a\"");
    send_byte(CH_NL, 1'b0);
  endtask

  // Single and doubled operators, operator after operator, operator ending a word.
  task automatic test_operators();
    send_text(">>>&||;a< &");
    send_byte(8'hC5, 1'b1);
  endtask

  // Empty quotes, and a quote left open at end of input and at a newline.
  task automatic test_quotes();
    send_text("\"\"\"x");
    send_byte(CH_QUOTE, 1'b1);
    send_text("\"\n");
  endtask

  // The receiver holds off while bytes keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    quiet         = 1'b1;
    long_hold_req = 1'b1;
    send_text("ab>>c&&d|e;f<g(h)||i \"q r\" >\n");
    while (long_hold_req) @(posedge clk);
    quiet = 1'b0;
  endtask

  function automatic logic [7:0] pick_word_char(bit allow_quote);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_NL || op_class(c) != 0 ||
           (c == CH_QUOTE && !allow_quote));
    return c;
  endfunction

  task automatic test_random_lines();
    int start;
    int n;
    int r;
    int len;
    logic [7:0] c;
    start = accepted_items;
    n     = 0;
    while (n < RANDOM_ITEMS) begin
      quiet = ((n / 60) % 3 == 2);
      r = $urandom_range(0, 99);
      if (r < 32) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_byte(pick_word_char(i > 0 && r < 4), 1'b0);
      end else if (r < 48) begin
        send_byte(CH_QUOTE, 1'b0);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_QUOTE || c == CH_NL);
          send_byte(c, 1'b0);
        end
        if ($urandom_range(0, 99) < 85) send_byte(CH_QUOTE, 1'b0);
      end else if (r < 64) begin
        c = OP_CHARS[$urandom_range(0, 6)];
        send_byte(c, 1'b0);
        if (op_class(c) == 2) begin
          len = $urandom_range(0, 9);
          if (len >= 5) send_byte(c, 1'b0);
          if (len == 9) send_byte(c, 1'b0);
        end
      end else if (r < 78) begin
        send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
      end else if (r < 90) begin
        if ($urandom_range(0, 1) != 0) send_byte(CH_NL, 1'b0);
        else send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
      n = accepted_items - start;
    end
    quiet = 1'b0;
  endtask

  initial begin
    lx_mode = MODE_IDLE;
    clear_operator();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_word_extremes();
    test_operators();
    test_quotes();
    test_output_backpressure();
    test_random_lines();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("shell_command_line_tokenizer regression: pass");
    end else begin
      $display("shell_command_line_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
